// ===== src/mbe_pkg.sv =====
package mbe_pkg;

	localparam int unsigned MAX_ROW_BYTES_DEF = 32;
	localparam int unsigned FIFO_DEPTH_DEF    = 4;

	localparam int unsigned XY_W       = 16;
	localparam int unsigned SIZE_W     = 8;
	localparam int unsigned COLOUR_W   = 16;
	localparam int unsigned WPX_W      = 8;
	localparam int unsigned BPR_W      = 6;
	localparam int unsigned ROW_W      = 8;
	localparam int unsigned PIX_BYTE   = 8;
	localparam int unsigned BIT_IDX_W  = 3;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ORIGIN_X      = 3'd0,
		REG_ORIGIN_Y      = 3'd1,
		REG_WIDTH_PX      = 3'd2,
		REG_BYTES_PER_ROW = 3'd3,
		REG_SCALE_FACTOR  = 3'd4,
		REG_FG_COLOUR     = 3'd5,
		REG_BG_COLOUR     = 3'd6,
		REG_OPAQUE_MODE   = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [XY_W-1:0]     origin_x;
		logic [XY_W-1:0]     origin_y;
		logic [WPX_W-1:0]    width_px;
		logic [BPR_W-1:0]    bytes_per_row;
		logic [SIZE_W-1:0]   scale_factor;
		logic [COLOUR_W-1:0] fg_colour;
		logic [COLOUR_W-1:0] bg_colour;
		logic                opaque_mode;
	} cfg_t;

	// One queued byte: mask/bits indexed by pixel offset (0 = leftmost)
	typedef struct packed {
		logic [PIX_BYTE-1:0] mask;
		logic [PIX_BYTE-1:0] bits;
		logic [XY_W-1:0]     x_base;
		logic [XY_W-1:0]     py;
	} cmd_entry_t;

	// zero scale behaves as one
	function automatic logic [SIZE_W-1:0] eff_scale(input logic [SIZE_W-1:0] s);
		return (s == '0) ? SIZE_W'(1) : s;
	endfunction

endpackage

// ===== src/mbe_front.sv =====
module mbe_front
	import mbe_pkg::*;
#(
	parameter int unsigned MAX_ROW_BYTES = MAX_ROW_BYTES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cfg_t                cfg,
	input  logic                push,
	input  logic [PIX_BYTE-1:0] data_byte,
	input  logic                last_byte,
	input  logic                q_full,
	output logic                full,
	output logic                q_push,
	output cmd_entry_t          q_entry
);

	localparam int unsigned BIR_W = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
	localparam int unsigned CB_W  = BIR_W + BIT_IDX_W;
	localparam int unsigned CMP_W = (CB_W > WPX_W) ? CB_W : WPX_W;
	localparam int unsigned XO_W  = CB_W + SIZE_W;
	localparam int unsigned RY_W  = ROW_W + SIZE_W;

	logic [BIR_W-1:0]    bir_q;
	logic [ROW_W-1:0]    row_q;
	logic                accept;
	logic [SIZE_W-1:0]   scale;
	logic [BPR_W:0]      rows;
	logic [BPR_W:0]      bir_next;
	logic [CB_W-1:0]     col_base;
	logic [XO_W-1:0]     x_off;
	logic [RY_W-1:0]     y_off;
	logic [CMP_W-1:0]    col;
	logic [PIX_BYTE-1:0] mask;
	logic [PIX_BYTE-1:0] bits;

	assign full   = q_full;
	assign accept = push && !q_full;
	assign scale  = eff_scale(cfg.scale_factor);

	// clamp bytes per row to 1..MAX_ROW_BYTES
	always_comb begin
		if (cfg.bytes_per_row == '0) begin
			rows = (BPR_W+1)'(1);
		end else if ({1'b0, cfg.bytes_per_row} > (BPR_W+1)'(MAX_ROW_BYTES)) begin
			rows = (BPR_W+1)'(MAX_ROW_BYTES);
		end else begin
			rows = {1'b0, cfg.bytes_per_row};
		end
	end

	assign bir_next = (BPR_W+1)'(bir_q) + (BPR_W+1)'(1);
	assign col_base = {bir_q, {BIT_IDX_W{1'b0}}};
	assign x_off    = XO_W'(col_base) * XO_W'(scale);
	assign y_off    = RY_W'(row_q) * RY_W'(scale);

	always_comb begin
		col  = '0;
		mask = '0;
		bits = '0;
		for (int b = 0; b < PIX_BYTE; b++) begin
			col     = CMP_W'(col_base) + CMP_W'(b);
			bits[b] = data_byte[PIX_BYTE-1-b];
			mask[b] = (col < CMP_W'(cfg.width_px)) && (bits[b] || cfg.opaque_mode);
		end
	end

	assign q_push         = accept && (mask != '0);
	assign q_entry.mask   = mask;
	assign q_entry.bits   = bits;
	assign q_entry.x_base = cfg.origin_x + XY_W'(x_off);
	assign q_entry.py     = cfg.origin_y + XY_W'(y_off);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bir_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (last_byte) begin
				bir_q <= '0;
				row_q <= '0;
			end else if (bir_next >= rows) begin
				bir_q <= '0;
				row_q <= row_q + ROW_W'(1);
			end else begin
				bir_q <= BIR_W'(bir_next);
			end
		end
	end

endmodule

// ===== src/mbe_fifo.sv =====
module mbe_fifo
	import mbe_pkg::*;
#(
	parameter int unsigned DEPTH = FIFO_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       wr_en,
	input  cmd_entry_t wr_data,
	input  logic       rd_en,
	output cmd_entry_t rd_data,
	output logic       q_full,
	output logic       q_empty
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	cmd_entry_t       mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign q_full  = (cnt_q == CNT_W'(DEPTH));
	assign q_empty = (cnt_q == '0);
	assign do_wr   = wr_en && !q_full;
	assign do_rd   = rd_en && !q_empty;
	assign rd_data = mem_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (do_rd) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule

// ===== src/mbe_back.sv =====
module mbe_back
	import mbe_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  cfg_t                cfg,
	input  logic                q_empty,
	input  cmd_entry_t          q_entry,
	output logic                q_pop,
	input  logic                pop,
	output logic                empty,
	output logic [XY_W-1:0]     pixel_x,
	output logic [XY_W-1:0]     pixel_y,
	output logic [SIZE_W-1:0]   block_size,
	output logic [COLOUR_W-1:0] colour,
	output logic                last_of_byte
);

	localparam int unsigned XO_W = BIT_IDX_W + SIZE_W;

	cmd_entry_t           cur_q;
	logic                 cur_valid_q;
	logic                 out_valid_q;
	logic [BIT_IDX_W-1:0] sel;
	logic [PIX_BYTE-1:0]  remaining;
	logic [SIZE_W-1:0]    scale;
	logic [XO_W-1:0]      x_off;
	logic                 out_free;
	logic                 advance;
	logic                 cur_done;

	assign scale = eff_scale(cfg.scale_factor);

	// leftmost pending pixel
	always_comb begin
		sel = '0;
		for (int b = PIX_BYTE - 1; b >= 0; b--) begin
			if (cur_q.mask[b]) begin
				sel = BIT_IDX_W'(b);
			end
		end
	end

	assign remaining = cur_q.mask & ~(PIX_BYTE'(1) << sel);
	assign x_off     = XO_W'(sel) * XO_W'(scale);
	assign out_free  = !out_valid_q || pop;
	assign advance   = cur_valid_q && out_free;
	assign cur_done  = advance && (remaining == '0);
	assign q_pop     = !q_empty && (!cur_valid_q || cur_done);
	assign empty     = !out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				cur_valid_q <= 1'b1;
			end else if (cur_done) begin
				cur_valid_q <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_entry;
		end else if (advance) begin
			cur_q.mask <= remaining;
		end
		if (advance) begin
			pixel_x      <= cur_q.x_base + XY_W'(x_off);
			pixel_y      <= cur_q.py;
			block_size   <= scale;
			colour       <= cur_q.bits[sel] ? cfg.fg_colour : cfg.bg_colour;
			last_of_byte <= (remaining == '0);
		end
	end

endmodule

// ===== src/mono_bitmap_expander_core.sv =====
// 1bpp bitmap colour expander.
// Input queue port: push a bitmap byte (MSB = leftmost pixel) with last_byte
// marking the final byte of the bitmap; a request is taken when push is high
// and full is low. Bytes arrive row-major, bytes_per_row bytes per row.
// Output queue port: one block-fill command per drawn pixel, taken when pop is
// high and empty is low. last_of_byte flags the final command of each byte.
// Bytes that draw nothing (padding, transparent zeros) produce no command.
// Path: the first command of a byte passes through the byte queue, the
// current-byte register and the output register. Throughput: one command per
// cycle while pop keeps the output free and the byte queue holds work; a byte
// yields one command per pixel it draws (0 to 8). Intake runs one byte per
// cycle while the FIFO_DEPTH-entry byte queue has room.
// Stall: with pop low the current command holds; the byte queue fills and
// then full rises. Nothing is dropped.
// Reset: queue and output empty, row/column counters at the top-left corner,
// registers at their defaults (8 px wide, 1 byte/row, scale 1, white fg).
// Configuration writes take effect at the next edge and are meant for idle.
module mono_bitmap_expander_core
	import mbe_pkg::*;
#(
	parameter int unsigned MAX_ROW_BYTES = MAX_ROW_BYTES_DEF,
	parameter int unsigned FIFO_DEPTH    = FIFO_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// config write port
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// byte input
	input  logic                  push,
	output logic                  full,
	input  logic [PIX_BYTE-1:0]   data_byte,
	input  logic                  last_byte,
	// command output
	output logic                  empty,
	input  logic                  pop,
	output logic [XY_W-1:0]       pixel_x,
	output logic [XY_W-1:0]       pixel_y,
	output logic [SIZE_W-1:0]     block_size,
	output logic [COLOUR_W-1:0]   colour,
	output logic                  last_of_byte
);

	cfg_t       cfg_q;
	logic       q_push;
	logic       q_pop;
	logic       q_full;
	logic       q_empty;
	cmd_entry_t q_wr;
	cmd_entry_t q_rd;

	// register file, reset to the documented defaults
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.origin_x      <= '0;
			cfg_q.origin_y      <= '0;
			cfg_q.width_px      <= WPX_W'(8);
			cfg_q.bytes_per_row <= BPR_W'(1);
			cfg_q.scale_factor  <= SIZE_W'(1);
			cfg_q.fg_colour     <= '1;
			cfg_q.bg_colour     <= '0;
			cfg_q.opaque_mode   <= 1'b0;
		end else if (cfg_wr_en) begin
			case (cfg_reg_t'(cfg_index))
				REG_ORIGIN_X:      cfg_q.origin_x      <= cfg_data[XY_W-1:0];
				REG_ORIGIN_Y:      cfg_q.origin_y      <= cfg_data[XY_W-1:0];
				REG_WIDTH_PX:      cfg_q.width_px      <= cfg_data[WPX_W-1:0];
				REG_BYTES_PER_ROW: cfg_q.bytes_per_row <= cfg_data[BPR_W-1:0];
				REG_SCALE_FACTOR:  cfg_q.scale_factor  <= cfg_data[SIZE_W-1:0];
				REG_FG_COLOUR:     cfg_q.fg_colour     <= cfg_data[COLOUR_W-1:0];
				REG_BG_COLOUR:     cfg_q.bg_colour     <= cfg_data[COLOUR_W-1:0];
				REG_OPAQUE_MODE:   cfg_q.opaque_mode   <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// front: row/column tracking, per-pixel draw mask, row/byte base coordinates
	mbe_front #(
		.MAX_ROW_BYTES(MAX_ROW_BYTES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.push      (push),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.q_full    (q_full),
		.full      (full),
		.q_push    (q_push),
		.q_entry   (q_wr)
	);

	// decouples byte intake from command emission
	mbe_fifo #(
		.DEPTH(FIFO_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_data (q_wr),
		.rd_en   (q_pop),
		.rd_data (q_rd),
		.q_full  (q_full),
		.q_empty (q_empty)
	);

	// back: walks the mask left to right, one command per cycle while pop keeps the output free
	mbe_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.q_empty      (q_empty),
		.q_entry      (q_rd),
		.q_pop        (q_pop),
		.pop          (pop),
		.empty        (empty),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.block_size   (block_size),
		.colour       (colour),
		.last_of_byte (last_of_byte)
	);

endmodule

// ===== src/mbe_checker.sv =====
module mbe_checker
	import mbe_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                empty,
	input logic                pop,
	input logic [XY_W-1:0]     pixel_x,
	input logic [XY_W-1:0]     pixel_y,
	input logic [SIZE_W-1:0]   block_size,
	input logic [COLOUR_W-1:0] colour,
	input logic                last_of_byte
);

	// held command stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(pixel_x) && $stable(pixel_y)
			&& $stable(colour) && $stable(last_of_byte))
		else $error("command changed while stalled");

	a_size_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> block_size != '0)
		else $error("zero block size");

	// rest of a byte follows without a bubble
	a_byte_cont: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && pop && !last_of_byte |=> !empty)
		else $error("gap inside a byte's commands");

	// commands of one byte share row and size
	a_same_row: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && pop && !last_of_byte |=> $stable(pixel_y) && $stable(block_size))
		else $error("row or size changed inside a byte");

endmodule

bind mono_bitmap_expander_core mbe_checker u_mbe_checker (.*);

// ===== verif/tb_top.sv =====
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import mbe_pkg::*;

	// Run limits.
	localparam int unsigned CYCLE_LIMIT = 200000;
	// Quiet time after the last command: covers queued bytes that draw nothing.
	localparam int unsigned SETTLE_CYCLES = 24;
	// The receiver holds off once, after this many bytes have gone in.
	localparam int unsigned HOLD_AT = 40;
	localparam int unsigned HOLD_CYCLES = 200;
	localparam int unsigned REPORT_MAX = 10;

	// One bitmap byte as it is pushed.
	typedef struct packed {
		logic [PIX_BYTE-1:0] data;
		logic                last;
	} bm_byte_t;

	// One block-fill command, laid out like the output ports.
	typedef struct packed {
		logic [XY_W-1:0]     x;
		logic [XY_W-1:0]     y;
		logic [SIZE_W-1:0]   size;
		logic [COLOUR_W-1:0] colour;
		logic                last;
	} draw_cmd_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                  cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	logic                push = 1'b0;
	logic                full;
	logic [PIX_BYTE-1:0] data_byte = '0;
	logic                last_byte = 1'b0;

	logic                empty;
	logic                pop = 1'b0;
	logic [XY_W-1:0]     pixel_x;
	logic [XY_W-1:0]     pixel_y;
	logic [SIZE_W-1:0]   block_size;
	logic [COLOUR_W-1:0] colour;
	logic                last_of_byte;

	mono_bitmap_expander_core DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.push         (push),
		.full         (full),
		.data_byte    (data_byte),
		.last_byte    (last_byte),
		.empty        (empty),
		.pop          (pop),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.block_size   (block_size),
		.colour       (colour),
		.last_of_byte (last_of_byte)
	);

	always #4 clk = ~clk;

	// Bytes waiting to be pushed, and the commands they must produce.
	bm_byte_t  bytes_q[$];
	draw_cmd_t draw_q[$];

	// Register image as the block should hold it, plus its row/column counters.
	cfg_t             cur_cfg;
	logic [4:0]       col_byte;
	logic [ROW_W-1:0] row_num;

	bit          idle_ok = 1'b1;   // random gaps on both sides when set
	int unsigned bytes_taken = 0;
	int unsigned n_bad = 0;
	int unsigned cycles = 0;

	// Bytes per row as the block applies it: zero acts as one, clamp at the max.
	function automatic int unsigned row_bytes(input logic [BPR_W-1:0] bpr);
		if (bpr == '0)
			return 1;
		if (bpr > MAX_ROW_BYTES_DEF)
			return MAX_ROW_BYTES_DEF;
		return bpr;
	endfunction

	// Expand one accepted byte into its expected fill commands, then step the
	// row/column counters.
	task automatic expand_byte(input bm_byte_t b);
		logic [SIZE_W-1:0] scl;
		logic [XY_W-1:0]   py;
		int unsigned       row_len;
		int unsigned       col;
		int unsigned       n;
		bit                px;
		draw_cmd_t         cmds[8];
		draw_cmd_t         c;
		scl = (cur_cfg.scale_factor == '0) ? SIZE_W'(1) : cur_cfg.scale_factor;
		row_len = row_bytes(cur_cfg.bytes_per_row);
		py = XY_W'(int'(cur_cfg.origin_y) + int'(row_num) * int'(scl));
		n = 0;
		for (int i = 0; i < PIX_BYTE; i++) begin
			col = int'(col_byte) * PIX_BYTE + i;
			px = b.data[PIX_BYTE - 1 - i];
			// padding columns and transparent zeros draw nothing
			if (col < cur_cfg.width_px && (px || cur_cfg.opaque_mode)) begin
				c.x = XY_W'(int'(cur_cfg.origin_x) + col * int'(scl));
				c.y = py;
				c.size = scl;
				c.colour = px ? cur_cfg.fg_colour : cur_cfg.bg_colour;
				c.last = 1'b0;
				cmds[n] = c;
				n++;
			end
		end
		if (n > 0)
			cmds[n - 1].last = 1'b1;
		for (int i = 0; i < n; i++)
			draw_q.push_back(cmds[i]);

		// A shrunk row length still ends the row on the current byte.
		if (b.last) begin
			col_byte = '0;
			row_num = '0;
		end else if (int'(col_byte) + 1 >= row_len) begin
			col_byte = '0;
			row_num = row_num + 1'b1;
		end else begin
			col_byte = col_byte + 1'b1;
		end
	endtask

	// ------------------------------------------------------------------
	// Driver: one request per accepted byte; push can drop for a random gap before it is taken.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : driver
		bm_byte_t b;
		if (arst_n) begin
			if (push && !full) begin
				b = bytes_q.pop_front();
				expand_byte(b);
				bytes_taken++;
			end
			if (bytes_q.size() != 0 && !(idle_ok && $urandom_range(99) < 8)) begin
				push <= 1'b1;
				data_byte <= bytes_q[0].data;
				last_byte <= bytes_q[0].last;
			end else begin
				push <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Receiver hold-off: a single long stretch with pop low that backs the
	// block up, counted in cycles here.
	// ------------------------------------------------------------------
	int unsigned stall_left = 0;
	bit          hold_done = 1'b0;

	always @(posedge clk) begin : hold_off
		if (arst_n) begin
			if (!hold_done && bytes_taken >= HOLD_AT) begin
				stall_left <= HOLD_CYCLES;
				hold_done <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left <= stall_left - 1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: check each popped command against the oldest expected one.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : monitor
		draw_cmd_t want;
		draw_cmd_t got;
		if (arst_n) begin
			if (pop && !empty) begin
				got = {pixel_x, pixel_y, block_size, colour, last_of_byte};
				if (draw_q.size() == 0) begin
					n_bad++;
					if (n_bad <= REPORT_MAX)
						$display("%0t: unexpected command x=%h y=%h size=%h colour=%h last=%b",
							$time, got.x, got.y, got.size, got.colour, got.last);
				end else begin
					want = draw_q.pop_front();
					if (got !== want) begin
						n_bad++;
						if (n_bad <= REPORT_MAX)
							$display({"%0t: command mismatch: expected x=%h y=%h size=%h ",
								"colour=%h last=%b, got x=%h y=%h size=%h colour=%h last=%b"},
								$time, want.x, want.y, want.size, want.colour, want.last,
								got.x, got.y, got.size, got.colour, got.last);
					end
				end
			end
			if (stall_left > 0) begin
				pop <= 1'b0;
			end else begin
				pop <= !(idle_ok && $urandom_range(99) < 8);
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	task automatic put_byte(input logic [PIX_BYTE-1:0] d, input logic lst);
		bm_byte_t b;
		b.data = d;
		b.last = lst;
		bytes_q.push_back(b);
	endtask

	// Wait until every byte is in and every command is out, then let bytes
	// that draw nothing clear the block.
	task automatic wait_idle();
		while (bytes_q.size() != 0 || push || draw_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
	endtask

	// Write every register; the block is idle when this is called.
	task automatic apply_config(input cfg_t c);
		write_reg(REG_ORIGIN_X, c.origin_x);
		write_reg(REG_ORIGIN_Y, c.origin_y);
		write_reg(REG_WIDTH_PX, CFG_DATA_W'(c.width_px));
		write_reg(REG_BYTES_PER_ROW, CFG_DATA_W'(c.bytes_per_row));
		write_reg(REG_SCALE_FACTOR, CFG_DATA_W'(c.scale_factor));
		write_reg(REG_FG_COLOUR, c.fg_colour);
		write_reg(REG_BG_COLOUR, c.bg_colour);
		write_reg(REG_OPAQUE_MODE, CFG_DATA_W'(c.opaque_mode));
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		cur_cfg = c;
	endtask

	function automatic logic [XY_W-1:0] pick_origin();
		case ($urandom_range(3))
			0: return '0;
			1: return '1;
			default: return XY_W'($urandom);
		endcase
	endfunction

	// Random register set, leaning on extremes and on widths near the row end.
	function automatic cfg_t pick_config();
		cfg_t        c;
		int unsigned row_len;
		c.origin_x = pick_origin();
		c.origin_y = pick_origin();
		case ($urandom_range(9))
			0: c.bytes_per_row = '0;
			1: c.bytes_per_row = BPR_W'(MAX_ROW_BYTES_DEF);
			2: c.bytes_per_row = '1;
			3: c.bytes_per_row = BPR_W'($urandom_range(63, 33));
			default: c.bytes_per_row = BPR_W'($urandom_range(4, 1));
		endcase
		row_len = row_bytes(c.bytes_per_row);
		case ($urandom_range(4))
			0: c.width_px = '0;
			1: c.width_px = '1;
			2: c.width_px = WPX_W'($urandom_range(255));
			default: c.width_px = WPX_W'(row_len * PIX_BYTE - $urandom_range(8, 1));
		endcase
		case ($urandom_range(4))
			0: c.scale_factor = '0;
			1: c.scale_factor = SIZE_W'(1);
			2: c.scale_factor = '1;
			default: c.scale_factor = SIZE_W'($urandom_range(255));
		endcase
		c.fg_colour = COLOUR_W'($urandom);
		c.bg_colour = COLOUR_W'($urandom);
		c.opaque_mode = 1'($urandom_range(1));
		return c;
	endfunction

	// Mostly whole bitmaps; some cut short, some stray bytes with a random
	// end flag that can leave the counters mid-row.
	task automatic queue_bitmaps(input int unsigned target);
		int unsigned row_len;
		int unsigned len;
		int unsigned added;
		int unsigned kind;
		row_len = row_bytes(cur_cfg.bytes_per_row);
		added = 0;
		while (added < target) begin
			kind = $urandom_range(9);
			len = row_len * ((row_len > 8) ? 1 : $urandom_range(3, 1));
			if (kind == 0) begin
				len = $urandom_range(6, 1);
				for (int i = 0; i < len; i++)
					put_byte(PIX_BYTE'($urandom), $urandom_range(3) == 0);
			end else begin
				if (kind == 1)
					len = $urandom_range(len, 1);
				for (int i = 0; i < len; i++)
					put_byte(PIX_BYTE'($urandom), i == len - 1);
			end
			added += len;
		end
	endtask

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin : stim
		cfg_t c;
		cur_cfg = '{origin_x: '0, origin_y: '0, width_px: WPX_W'(8),
			bytes_per_row: BPR_W'(1), scale_factor: SIZE_W'(1),
			fg_colour: '1, bg_colour: '0, opaque_mode: 1'b0};
		col_byte = '0;
		row_num = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset defaults, transparent: an all-clear byte draws nothing.
		put_byte(8'hFF, 1'b0);
		put_byte(8'h00, 1'b0);
		put_byte(8'h80, 1'b0);
		put_byte(8'h01, 1'b1);
		wait_idle();

		// Opaque, origin at the top of the range so x and y wrap, zero scale,
		// 12 px over 2 bytes/row so the second byte has padding.
		c = '{origin_x: '1, origin_y: '1, width_px: WPX_W'(12),
			bytes_per_row: BPR_W'(2), scale_factor: '0,
			fg_colour: 16'h1234, bg_colour: 16'hABCD, opaque_mode: 1'b1};
		apply_config(c);
		put_byte(8'hAA, 1'b0);
		put_byte(8'h55, 1'b0);
		put_byte(8'h0F, 1'b0);
		put_byte(8'hF0, 1'b1);
		wait_idle();

		// Width past the row end, max scale; stop three bytes into a 4-byte row.
		c = '{origin_x: '0, origin_y: 16'h0100, width_px: '1,
			bytes_per_row: BPR_W'(4), scale_factor: '1,
			fg_colour: 16'hF800, bg_colour: 16'h07E0, opaque_mode: 1'b0};
		apply_config(c);
		put_byte(8'hFF, 1'b0);
		put_byte(8'h81, 1'b0);
		put_byte(8'h00, 1'b0);
		wait_idle();

		// Row length cut below the current column: next byte closes the row.
		c.bytes_per_row = BPR_W'(2);
		c.opaque_mode = 1'b1;
		apply_config(c);
		put_byte(8'hC3, 1'b0);
		put_byte(8'h3C, 1'b0);
		put_byte(8'h7E, 1'b1);
		wait_idle();

		// Zero bytes per row acts as one.
		c.bytes_per_row = '0;
		c.width_px = WPX_W'(16);
		apply_config(c);
		put_byte(8'h99, 1'b0);
		put_byte(8'h66, 1'b1);
		wait_idle();

		// Bytes per row above the max is clamped.
		c.bytes_per_row = '1;
		c.width_px = '1;
		c.scale_factor = SIZE_W'(7);
		apply_config(c);
		put_byte(8'hFF, 1'b0);
		put_byte(8'h00, 1'b1);
		wait_idle();

		// Long run with no gaps: one byte per row for more than 256 rows so
		// the row counter wraps. The receiver's hold-off lands in here.
		c = pick_config();
		c.bytes_per_row = BPR_W'(1);
		c.width_px = WPX_W'(8);
		c.opaque_mode = 1'b1;
		c.scale_factor = SIZE_W'($urandom_range(255, 1));
		apply_config(c);
		idle_ok = 1'b0;
		for (int i = 0; i < 259; i++)
			put_byte(PIX_BYTE'($urandom), 1'b0);
		put_byte(PIX_BYTE'($urandom), 1'b1);
		wait_idle();
		idle_ok = 1'b1;

		// Random register sets, at least twenty bytes each.
		for (int p = 0; p < 3; p++) begin
			apply_config(pick_config());
			queue_bitmaps(20);
			wait_idle();
		end

		if (n_bad == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule

// ===== files.f =====
src/mbe_pkg.sv
src/mbe_front.sv
src/mbe_fifo.sv
src/mbe_back.sv
src/mono_bitmap_expander_core.sv
src/mbe_checker.sv
verif/tb_top.sv
